// File: rtl/core/pocsag_transmission_framer_unit_defines.svh
// assertion macros for the pocsag transmission framer checker
// expects clk and rst in the scope where a macro is used
`ifndef POCSAG_TRANSMISSION_FRAMER_UNIT_DEFINES_SVH
`define POCSAG_TRANSMISSION_FRAMER_UNIT_DEFINES_SVH

// condition holds at every clock outside reset
`define PTF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ptf_pkg.sv
// shared constants, item kinds and codeword function for the pocsag framer
// no dependencies
package ptf_pkg;

  localparam int PREAMBLE_WORDS = 18;
  localparam int PRE_CNT_W      = $clog2(PREAMBLE_WORDS + 1);

  localparam logic [31:0] SYNC_WORD        = 32'h7CD2_15D8;
  localparam logic [31:0] IDLE_WORD        = 32'h7A89_C197;
  localparam logic [31:0] PREAMBLE_PATTERN = 32'hAAAA_AAAA;

  localparam logic [10:0] BCH_GEN = 11'b11101101001;
  localparam int DATA_BITS    = 21;
  localparam int CHECK_BITS   = 10;
  localparam int CHAR_BITS    = 7;
  localparam int PAYLOAD_BITS = 20;
  localparam int BATCH_SLOTS  = 16;
  localparam int BATCH_W      = $clog2(BATCH_SLOTS);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef logic [DATA_BITS-1:0][CHECK_BITS-1:0] bch_cols_t;

  // remainder of x^(i+10) mod g for each data bit, evaluated at elaboration
  function automatic bch_cols_t bch_cols_build();
    bch_cols_t   t;
    logic [30:0] r;
    for (int i = 0; i < DATA_BITS; i++) begin
      r = 31'(1) << (i + CHECK_BITS);
      for (int b = 30; b >= CHECK_BITS; b--) begin
        if (r[b]) begin
          r = r ^ (31'(BCH_GEN) << (b - CHECK_BITS));
        end
      end
      t[i] = r[CHECK_BITS-1:0];
    end
    return t;
  endfunction

  localparam bch_cols_t BCH_COLS = bch_cols_build();

  // bch(31,21) check bits by xor of constant columns, then even parity
  function automatic logic [31:0] bch_codeword(input logic [DATA_BITS-1:0] data);
    logic [CHECK_BITS-1:0] check;
    logic [30:0]           body;
    check = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (data[i]) begin
        check = check ^ BCH_COLS[i];
      end
    end
    body = {data, check};
    return {body, ^body};
  endfunction

endpackage

// File: rtl/core/pocsag_transmission_framer_unit.sv
// The first word of an item goes through the plan register, then the output register.
// One word per cycle while out_ready is high; an item holds the input until its last
//   word is sent (a start item has 20 to 34 words), items with no words go one per cycle.
// The word rate is set by the single plan register feeding the output register.
// Reset (rst, synchronous): drops any pending words, closes the message, clears
//   the bit accumulator and batch position.
module pocsag_transmission_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [20:0] address,
  input  logic [1:0]  function_code,
  input  logic [6:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] word,
  output logic        last
);

  localparam int PW = ptf_pkg::PAYLOAD_BITS;
  localparam int BW = ptf_pkg::BATCH_W;
  localparam int CW = ptf_pkg::CHAR_BITS;
  localparam logic [BW-1:0] LAST_SLOT = BW'(ptf_pkg::BATCH_SLOTS - 1);
  localparam logic [4:0] WRAP_COUNT = 5'(PW - CW);

  // word groups in send order, lowest set bit goes first
  typedef struct packed {
    logic idle_d;
    logic sync_c;
    logic idle_c;
    logic sync_b;
    logic cw;
    logic idle_a;
    logic sync_a;
    logic pre;
  } group_mask_t;

  typedef struct packed {
    group_mask_t                        mask;
    logic [ptf_pkg::PRE_CNT_W-1:0]      pre_cnt;
    logic [3:0]                         idle_a_cnt;
    logic [4:0]                         idle_d_cnt;
    logic [ptf_pkg::DATA_BITS-1:0]      data;
  } plan_t;

  plan_t plan;
  plan_t plan_next;
  plan_t plan_after;

  logic [PW-1:0]   bit_accumulator;
  logic [4:0]      bit_count;
  logic [BW-1:0]   batch_position;
  logic            message_active;
  logic [PW-1:0]   bit_accumulator_next;
  logic [4:0]      bit_count_next;
  logic [BW-1:0]   batch_position_next;
  logic            message_active_next;

  logic        in_accept;
  logic        emit_go;
  logic        last_sel;
  logic [31:0] word_sel;

  // ---------------------------------------------------------------- planning
  logic [CW-1:0]      char_rev;
  logic [PW+CW-1:0]   combined;
  logic [PW+CW-1:0]   shifted;
  logic [2:0]         sh;
  logic [CW-1:0]      low_mask;
  logic [4:0]         tail_shift;
  logic [PW-1:0]      tail_bits;
  logic [BW-1:0]      pos1;
  logic [BW-1:0]      pos2;

  always_comb begin
    plan_next            = '0;
    bit_accumulator_next = bit_accumulator;
    bit_count_next       = bit_count;
    batch_position_next  = batch_position;
    message_active_next  = message_active;

    for (int i = 0; i < CW; i++) begin
      char_rev[CW-1-i] = char_code[i];
    end
    combined   = {bit_accumulator, char_rev};
    sh         = 3'(bit_count - WRAP_COUNT);
    shifted    = combined >> sh;
    low_mask   = ~({CW{1'b1}} << sh);
    tail_shift = 5'(PW) - bit_count;
    tail_bits  = bit_accumulator << tail_shift;
    pos1       = batch_position;
    pos2       = batch_position;

    unique case (kind)
      ptf_pkg::KIND_START: begin
        plan_next.mask.pre    = 1'b1;
        plan_next.mask.sync_a = 1'b1;
        plan_next.mask.idle_a = (address[2:0] != 3'd0);
        plan_next.mask.cw     = 1'b1;
        plan_next.pre_cnt     = ptf_pkg::PRE_CNT_W'(ptf_pkg::PREAMBLE_WORDS);
        plan_next.idle_a_cnt  = {address[2:0], 1'b0};
        plan_next.data        = {1'b0, address[20:3], function_code};
        bit_accumulator_next  = '0;
        bit_count_next        = '0;
        batch_position_next   = {address[2:0], 1'b1};
        message_active_next   = 1'b1;
      end
      ptf_pkg::KIND_CHAR: begin
        if (message_active) begin
          if (bit_count >= WRAP_COUNT) begin
            // payload fills partway through this character
            plan_next.mask.cw     = 1'b1;
            plan_next.mask.sync_b = (batch_position == LAST_SLOT);
            plan_next.data        = {1'b1, shifted[PW-1:0]};
            bit_accumulator_next  = PW'(combined[CW-1:0] & low_mask);
            bit_count_next        = 5'(sh);
            batch_position_next   = batch_position + 1'b1;
          end else begin
            bit_accumulator_next = combined[PW-1:0];
            bit_count_next       = bit_count + 5'(CW);
          end
        end
      end
      ptf_pkg::KIND_END: begin
        if (message_active) begin
          if (bit_count != 5'd0) begin
            plan_next.mask.cw     = 1'b1;
            plan_next.mask.sync_b = (batch_position == LAST_SLOT);
            plan_next.data        = {1'b1, tail_bits};
            pos1                  = batch_position + 1'b1;
          end
          plan_next.mask.idle_c = 1'b1;
          plan_next.mask.sync_c = (pos1 == LAST_SLOT);
          pos2                  = pos1 + 1'b1;
          plan_next.mask.idle_d = 1'b1;
          plan_next.idle_d_cnt  = 5'(ptf_pkg::BATCH_SLOTS) - {1'b0, pos2};
          bit_accumulator_next  = '0;
          bit_count_next        = '0;
          batch_position_next   = '0;
          message_active_next   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // ----------------------------------------------------------------- emitter
  always_comb begin
    plan_after = plan;
    word_sel   = ptf_pkg::IDLE_WORD;
    priority if (plan.mask.pre) begin
      word_sel           = ptf_pkg::PREAMBLE_PATTERN;
      plan_after.pre_cnt = plan.pre_cnt - 1'b1;
      if (plan.pre_cnt == ptf_pkg::PRE_CNT_W'(1)) begin
        plan_after.mask.pre = 1'b0;
      end
    end else if (plan.mask.sync_a) begin
      word_sel               = ptf_pkg::SYNC_WORD;
      plan_after.mask.sync_a = 1'b0;
    end else if (plan.mask.idle_a) begin
      plan_after.idle_a_cnt = plan.idle_a_cnt - 1'b1;
      if (plan.idle_a_cnt == 4'd1) begin
        plan_after.mask.idle_a = 1'b0;
      end
    end else if (plan.mask.cw) begin
      word_sel           = ptf_pkg::bch_codeword(plan.data);
      plan_after.mask.cw = 1'b0;
    end else if (plan.mask.sync_b) begin
      word_sel               = ptf_pkg::SYNC_WORD;
      plan_after.mask.sync_b = 1'b0;
    end else if (plan.mask.idle_c) begin
      plan_after.mask.idle_c = 1'b0;
    end else if (plan.mask.sync_c) begin
      word_sel               = ptf_pkg::SYNC_WORD;
      plan_after.mask.sync_c = 1'b0;
    end else if (plan.mask.idle_d) begin
      plan_after.idle_d_cnt = plan.idle_d_cnt - 1'b1;
      if (plan.idle_d_cnt == 5'd1) begin
        plan_after.mask.idle_d = 1'b0;
      end
    end else begin
      word_sel = ptf_pkg::IDLE_WORD;
    end
  end

  assign last_sel  = (plan_after.mask == '0);
  assign emit_go   = (plan.mask != '0) && (!out_valid || out_ready);
  assign in_ready  = (plan.mask == '0) || (emit_go && last_sel);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plan.mask       <= '0;
      out_valid       <= 1'b0;
      bit_accumulator <= '0;
      bit_count       <= '0;
      batch_position  <= '0;
      message_active  <= 1'b0;
    end else begin
      if (in_accept) begin
        plan            <= plan_next;
        bit_accumulator <= bit_accumulator_next;
        bit_count       <= bit_count_next;
        batch_position  <= batch_position_next;
        message_active  <= message_active_next;
      end else if (emit_go) begin
        plan <= plan_after;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
        word      <= word_sel;
        last      <= last_sel;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/ptf_checker.sv
// port-level checks for the pocsag framer, bound to the top level
// depends on ptf_pkg and the framer defines header
`include "pocsag_transmission_framer_unit_defines.svh"

module ptf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] word,
  input logic        last
);

  // a stalled beat keeps its word
  `PTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(word) && $stable(last),
                   "output beat changed while stalled")

  // preamble never ends an item's run
  `PTF_ASSERT_SAME(a_pre_not_last, out_valid && word == ptf_pkg::PREAMBLE_PATTERN, !last,
                   "preamble word flagged last")

  // a run of words has no gaps
  `PTF_ASSERT_NEXT(a_run_no_gap, out_valid && out_ready && !last, out_valid,
                   "gap inside a word run")

  // no new item while a run is stuck mid-way
  `PTF_ASSERT_SAME(a_busy_mid_run, out_valid && !out_ready && !last, !in_ready,
                   "input taken while run stalled")

endmodule

bind pocsag_transmission_framer_unit ptf_checker u_ptf_checker (.*);
